// ===== src/nat_pkg.sv =====
// Shared types and constants for the node address table.
// No dependencies.
package nat_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_DELETE   = 3'd2,
        CMD_KEEP_GW  = 3'd3,
        CMD_BY_ADDR  = 3'd4,
        CMD_BY_NODE  = 3'd5,
        CMD_RENAME   = 3'd6,
        CMD_SET_SUFX = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_GATEWAY = 2'd0,
        CFG_HOST    = 2'd1,
        CFG_MASK    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the command
        logic start;    // reset scan pointer
        logic step;     // process one entry
        logic finish;   // apply end-of-command effects
        logic emit;     // load the output register
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// ===== src/nat_node_address_table.sv =====
// Top level of the node address table: joins controller and datapath.
// Depends on nat_pkg, nat_ctrl and nat_dpath.
//
// Each command scans the stored entries one per cycle through a single
// read port of the entry memory (the entry count is at most 256). The
// result waits for the previous result to be transferred. A delete
// compacts the table during that same scan. No clearing pass is needed
// after reset.
module nat_node_address_table
    import nat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_cmd,
    input  logic [11:0]       i_node_id,
    input  logic [11:0]       i_new_node_id,
    input  logic [31:0]       i_ip_addr,
    input  logic [15:0]       i_suffix_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_success,
    output logic [11:0]       o_node_out,
    output logic [31:0]       o_ip_out,
    output logic [CNT_W-1:0]  o_count_out,
    output logic              o_all_have_address
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    nat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    nat_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_node_id          (i_node_id),
        .i_new_node_id      (i_new_node_id),
        .i_ip_addr          (i_ip_addr),
        .i_suffix_value     (i_suffix_value),
        .o_success          (o_success),
        .o_node_out         (o_node_out),
        .o_ip_out           (o_ip_out),
        .o_count_out        (o_count_out),
        .o_all_have_address (o_all_have_address)
    );

endmodule

// ===== src/nat_ctrl.sv =====
// Controller state machine for the node address table.
// Depends on nat_pkg.
module nat_ctrl
    import nat_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_sts   i_sts,
    output t_ctl   o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (i_sts.scan_done) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT:    if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.load   = i_in_valid;
                o_ctl.start  = i_in_valid;
            end
            ST_SCAN:   o_ctl.step = !i_sts.scan_done;
            ST_FINISH: o_ctl.finish = 1'b1;
            ST_OUT: begin
                // The previous result must have been transferred first.
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.emit  = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE)
        else $error("ready outside idle");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit |=> r_state == ST_IDLE && o_out_valid)
        else $error("emit did not produce a result");
`endif

endmodule

// ===== src/nat_dpath.sv =====
// Datapath for the node address table: entry memories, scan pointer,
// command registers and result register. Depends on nat_pkg.
module nat_dpath
    import nat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    output t_sts              o_sts,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [2:0]        i_cmd,
    input  logic [11:0]       i_node_id,
    input  logic [11:0]       i_new_node_id,
    input  logic [31:0]       i_ip_addr,
    input  logic [15:0]       i_suffix_value,
    output logic              o_success,
    output logic [11:0]       o_node_out,
    output logic [31:0]       o_ip_out,
    output logic [CNT_W-1:0]  o_count_out,
    output logic              o_all_have_address
);

    // Configuration registers.
    logic [11:0] r_gw;
    logic [31:0] r_host, r_mask;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= 12'd1;
            r_host <= '0;
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GATEWAY: r_gw   <= i_cfg_data[11:0];
                CFG_HOST:    r_host <= i_cfg_data;
                CFG_MASK:    r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Memories: one read port, one write port each.
    logic [11:0] m_node [TABLE_DEPTH];
    logic [15:0] m_sufx [TABLE_DEPTH];

    logic [2:0]       r_cmd;
    logic [11:0]      r_node, r_new;
    logic [31:0]      r_ip;
    logic [15:0]      r_sval;
    logic [CNT_W-1:0] r_count;

    // Scan: r_ptr is the read address, r_rv marks that rd data belongs to r_rptr.
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_rptr;
    logic             r_rv;
    logic [11:0]      r_rd_node;
    logic [15:0]      r_rd_sufx;

    // Scan results.
    logic             r_found;      // first match seen (add, delete, set, lookups)
    logic [11:0]      r_fnode;
    logic [15:0]      r_fsufx;
    logic [11:0]      r_keep_node;
    logic [15:0]      r_keep_sufx;
    logic             r_keep_set;
    logic             r_zero;       // some entry has a zero suffix (after cmd)
    logic             r_full;       // table was full when the command arrived

    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [11:0] wr_node;
    logic [15:0] wr_sufx;

    logic [15:0] gw_sufx;
    logic [15:0] want;
    logic        addr_ok;
    logic        rd_ok;
    logic        in_scan;
    logic [IDX_W-1:0] rd_idx;
    assign gw_sufx = r_host[15:0] & ~r_mask[15:0];
    assign want    = r_ip[15:0] & ~r_mask[15:0];
    assign addr_ok = (r_ip & r_mask) == (r_host & r_mask);
    assign rd_ok   = r_rv && (r_rptr < r_count);
    assign rd_idx  = r_rptr[IDX_W-1:0];

    // Scan runs until the pipeline has retired entry count-1.
    assign in_scan = r_ptr < r_count;
    assign o_sts.scan_done = !in_scan && !r_rv;

    // Per-entry match, given the captured command.
    logic match_node;
    assign match_node = rd_ok && (r_rd_node == r_node);

    // Entry value after this command's per-entry effect.
    logic [11:0] eff_node;
    logic [15:0] eff_sufx;
    logic        shift_mode;
    always_comb begin
        eff_node = r_rd_node;
        eff_sufx = r_rd_sufx;
        if (r_cmd == CMD_RENAME && match_node) eff_node = r_new;
        if (r_cmd == CMD_SET_SUFX && match_node && !r_found) eff_sufx = r_sval;
    end
    // Delete compaction: after the first match, move each entry down.
    assign shift_mode = (r_cmd == CMD_DELETE) && (r_node != r_gw) && r_found;

    always_comb begin
        wr_en = 1'b0; wr_addr = rd_idx; wr_node = eff_node; wr_sufx = eff_sufx;
        if (i_ctl.step && rd_ok) begin
            if (r_cmd == CMD_RENAME && match_node) wr_en = 1'b1;
            if (r_cmd == CMD_SET_SUFX && match_node && !r_found) wr_en = 1'b1;
            if (shift_mode) begin
                wr_en = 1'b1;
                wr_addr = rd_idx - 1'b1;
            end
        end else if (i_ctl.finish) begin
            if (r_cmd == CMD_ADD && !r_found && r_count < CNT_W'(TABLE_DEPTH)) begin
                wr_en   = 1'b1;
                wr_addr = r_count[IDX_W-1:0];
                wr_node = r_node;
                wr_sufx = (r_node == r_gw) ? gw_sufx : 16'd0;
            end else if (r_cmd == CMD_KEEP_GW) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_node = r_keep_node;
                wr_sufx = r_keep_sufx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_node[wr_addr] <= wr_node;
            m_sufx[wr_addr] <= wr_sufx;
        end
        r_rd_node <= m_node[r_ptr[IDX_W-1:0]];
        r_rd_sufx <= m_sufx[r_ptr[IDX_W-1:0]];
    end

    // Zero-suffix tracking for entries that stay in the table.
    logic keeps_entry;
    assign keeps_entry = !(r_cmd == CMD_DELETE && r_node != r_gw && match_node && !r_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_ptr <= '0;
                r_rv  <= 1'b0;
            end else if (i_ctl.step) begin
                r_rv   <= in_scan;
                r_rptr <= r_ptr;
                if (in_scan) r_ptr <= r_ptr + 1'b1;
            end
            if (i_ctl.finish) begin
                case (r_cmd)
                    CMD_CLEAR:   r_count <= '0;
                    CMD_ADD:     if (!r_found && r_count < CNT_W'(TABLE_DEPTH))
                                     r_count <= r_count + 1'b1;
                    CMD_DELETE:  if (r_node != r_gw && r_found) r_count <= r_count - 1'b1;
                    CMD_KEEP_GW: r_count <= CNT_W'(1);
                    default: ;
                endcase
            end
        end
    end

    logic [15:0] suffix_new;
    assign suffix_new = (r_node == r_gw) ? gw_sufx : 16'd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_node <= i_node_id;
            r_new  <= i_new_node_id;
            r_ip   <= i_ip_addr;
            r_sval <= i_suffix_value;
            r_found <= 1'b0;
            r_keep_set <= 1'b0;
            r_zero <= 1'b0;
            // An add that arrives at a full table is refused.
            r_full <= (r_count == CNT_W'(TABLE_DEPTH));
        end else if (i_ctl.step && rd_ok) begin
            if (keeps_entry && eff_sufx == 16'd0) r_zero <= 1'b1;
            if (!r_found) begin
                case (r_cmd) inside
                    CMD_BY_ADDR: if (r_rd_sufx == want) begin
                        r_found <= 1'b1; r_fnode <= r_rd_node;
                    end
                    CMD_BY_NODE: if (match_node && r_rd_sufx != 16'd0) begin
                        r_found <= 1'b1; r_fsufx <= r_rd_sufx;
                    end
                    CMD_ADD, CMD_DELETE, CMD_SET_SUFX: if (match_node) begin
                        r_found <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (r_cmd == CMD_KEEP_GW && (r_rd_node == r_gw || !r_keep_set)) begin
                r_keep_set  <= 1'b1;
                r_keep_node <= r_rd_node;
                r_keep_sufx <= r_rd_sufx;
            end
        end else if (i_ctl.finish && r_cmd == CMD_ADD && !r_found && !r_full) begin
            // The appended entry also counts toward the zero-suffix flag.
            if (suffix_new == 16'd0) r_zero <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_success   <= 1'b0;
            o_node_out  <= '0;
            o_ip_out    <= '0;
            o_count_out <= '0;
            o_all_have_address <= !r_zero;
            case (r_cmd)
                CMD_CLEAR: begin
                    o_success <= 1'b1;
                    o_all_have_address <= 1'b1;
                end
                CMD_ADD: if (!r_full) begin
                    // Count was already updated in the finish cycle.
                    o_success   <= 1'b1;
                    o_count_out <= r_count;
                end
                CMD_DELETE: if (r_node != r_gw && r_found) begin
                    o_success   <= 1'b1;
                    o_count_out <= CNT_W'(1);
                end
                CMD_KEEP_GW: begin
                    o_success <= 1'b1;
                    o_all_have_address <= r_keep_sufx != 16'd0;
                end
                CMD_BY_ADDR: if (addr_ok && r_found) begin
                    o_success  <= 1'b1;
                    o_node_out <= r_fnode;
                end
                CMD_BY_NODE: if (r_found) begin
                    o_success <= 1'b1;
                    o_ip_out  <= {r_host[31:16], (r_host[15:0] & r_mask[15:0]) | r_fsufx};
                end
                CMD_RENAME: o_success <= 1'b1;
                CMD_SET_SUFX: o_success <= r_found;
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above depth");
    a_keep_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish && r_cmd == CMD_KEEP_GW |=> r_count == CNT_W'(1))
        else $error("delete-all did not leave one entry");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish && r_cmd == CMD_CLEAR |=> r_count == '0)
        else $error("clear left entries");
`endif

endmodule
